>>> rtl/bdd_pkg.sv
// Shared types and constants for the bit destuffing flag deframer.
package bdd_pkg;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_OK       = 2'd1,
    KIND_FRACTION = 2'd2,
    KIND_NO_CLOSE = 2'd3
  } result_kind_t;

  localparam int ByteW  = 8;
  localparam int FlLenW = 16;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [2:0] StuffRun = 3'd5;
  localparam logic [2:0] FlagRun  = 3'd6;
  localparam logic [2:0] RunMax   = 3'd7;
  localparam logic [2:0] LastBit  = 3'd7;

  typedef struct packed {
    result_kind_t        kind;
    logic [ByteW-1:0]    payload;
    logic [FlLenW-1:0]   length;
    logic                last;
  } result_t;

  // up to two results per request; r1 only with r0
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

>>> rtl/bdd_if.sv
// Channel interfaces: line byte requests in, deframer results out.
interface bdd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       input_done;

  modport source (output valid, output line_byte, output input_done, input ready);
  modport sink   (input valid, input line_byte, input input_done, output ready);
endinterface

interface bdd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] frame_length;
  logic        last_result;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_length, output last_result, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input frame_length, input last_result, output ready);
endinterface

>>> rtl/bit_destuffing_deframer_unit.sv
// Top level of the bit destuffing flag deframer.
// A taken request waits in the input register; its results then go to the result queue,
// whose head drives the output. One line byte is taken per cycle while the queue has room;
// one result leaves per cycle while out ready; a data byte and a frame end are two results.
// Reset (rst_n low, synchronous) returns to hunting with all counts cleared and queue empty.
module bit_destuffing_deframer_unit #(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bdd_in_if.sink     in_ch,
  bdd_out_if.source  out_ch
);
  import bdd_pkg::*;

  push_t   push;
  logic    room;
  result_t head;

  bdd_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .line_byte  (in_ch.line_byte),
    .input_done (in_ch.input_done),
    .room       (room),
    .push       (push)
  );

  bdd_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (head)
  );

  assign out_ch.result_kind  = head.kind;
  assign out_ch.payload_byte = head.payload;
  assign out_ch.frame_length = head.length;
  assign out_ch.last_result  = head.last;

endmodule

>>> rtl/bdd_core.sv
// Input register, deframer state and the unrolled eight-bit destuff step.
module bdd_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      line_byte,
  input  logic            input_done,
  input  logic            room,
  output bdd_pkg::push_t  push
);
  import bdd_pkg::*;

  localparam logic [LENGTH_BITS-1:0] TotalMax = {LENGTH_BITS{1'b1}};

  logic                   hold_v_r, hold_v_nxt;
  logic [ByteW-1:0]       byte_r;
  logic                   done_r;
  logic                   in_frame_r, in_frame_nxt;
  logic [2:0]             ones_r, ones_nxt;
  logic [2:0]             pend_r, pend_nxt;
  logic [ByteW-1:0]       part_r, part_nxt;
  logic [LENGTH_BITS-1:0] total_r, total_nxt;

  logic                   fire;
  logic                   inf, stop, bitv, data_hit, end_hit;
  logic [2:0]             ones, pend, idx;
  logic [ByteW-1:0]       part, data_byte;
  result_kind_t           end_kind;
  logic [LENGTH_BITS-1:0] tot_new;
  logic [31:0]            tot_ext, cur_ext;

  assign fire       = hold_v_r && room;
  assign in_ready   = !hold_v_r || fire;
  assign hold_v_nxt = (in_valid && in_ready) || (hold_v_r && !fire);

  always_comb begin
    inf       = in_frame_r;
    ones      = ones_r;
    pend      = pend_r;
    part      = part_r;
    stop      = 1'b0;
    bitv      = 1'b0;
    idx       = '0;
    data_hit  = 1'b0;
    end_hit   = 1'b0;
    data_byte = '0;
    end_kind  = KIND_OK;
    for (int i = 0; i < ByteW; i++) begin
      if (!stop) begin
        bitv = byte_r[ByteW-1-i];
        if (inf && ones != StuffRun) begin
          idx       = LastBit - pend;
          part[idx] = bitv;
          if (pend == LastBit) begin
            data_hit  = 1'b1;
            data_byte = part;
            part      = '0;
            pend      = '0;
          end else begin
            pend = pend + 3'd1;
          end
        end
        if (bitv) begin
          if (ones != RunMax) ones = ones + 3'd1;
        end else begin
          if (ones == FlagRun) begin
            if (!inf) begin
              inf = 1'b1;
            end else begin
              end_hit  = 1'b1;
              end_kind = (pend == LastBit) ? KIND_OK : KIND_FRACTION;
              inf      = 1'b0;
              pend     = '0;
              part     = '0;
              stop     = 1'b1;
            end
          end
          ones = '0;
        end
      end
    end
  end

  always_comb begin
    tot_new = total_r;
    if (data_hit && total_r != TotalMax) tot_new = total_r + 1'b1;
    tot_ext = 32'(tot_new);
    cur_ext = 32'(total_r);

    push = '0;
    if (done_r) begin
      push.v0 = fire;
      push.r0 = '{kind: KIND_NO_CLOSE, payload: '0, length: cur_ext[FlLenW-1:0], last: 1'b1};
      in_frame_nxt = 1'b0;
      ones_nxt     = '0;
      pend_nxt     = '0;
      part_nxt     = '0;
      total_nxt    = '0;
    end else begin
      in_frame_nxt = inf;
      ones_nxt     = ones;
      pend_nxt     = pend;
      part_nxt     = part;
      total_nxt    = end_hit ? '0 : tot_new;
      if (data_hit) begin
        push.v0 = fire;
        push.r0 = '{kind: KIND_DATA, payload: data_byte,
                    length: tot_ext[FlLenW-1:0], last: !end_hit};
        if (end_hit) begin
          push.v1 = fire;
          push.r1 = '{kind: end_kind, payload: '0, length: tot_ext[FlLenW-1:0], last: 1'b1};
        end
      end else if (end_hit) begin
        push.v0 = fire;
        push.r0 = '{kind: end_kind, payload: '0, length: tot_ext[FlLenW-1:0], last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r   <= 1'b0;
      in_frame_r <= 1'b0;
      ones_r     <= '0;
      pend_r     <= '0;
      part_r     <= '0;
      total_r    <= '0;
    end else begin
      hold_v_r <= hold_v_nxt;
      if (fire) begin
        in_frame_r <= in_frame_nxt;
        ones_r     <= ones_nxt;
        pend_r     <= pend_nxt;
        part_r     <= part_nxt;
        total_r    <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= line_byte;
      done_r <= input_done;
    end
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.v0 || push.v1) |-> room)
    else $error("result pushed without queue room");

  a_hunt_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (pend_r == '0 && part_r == '0))
    else $error("bits pending while hunting");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && done_r) |=> (!in_frame_r && total_r == '0 && ones_r == '0))
    else $error("end of input did not clear state");

endmodule

>>> rtl/bdd_rq.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
module bdd_rq (
  input  logic              clk,
  input  logic              rst_n,
  input  bdd_pkg::push_t    push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output bdd_pkg::result_t  out_res
);
  import bdd_pkg::*;

  result_t          mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPtrW:0]   cnt_r, cnt_nxt;
  logic             pop;
  logic [QPtrW:0]   n_push;

  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign room      = cnt_r <= (QPtrW+1)'(QDepth - 2);

  always_comb begin
    n_push  = (QPtrW+1)'(push.v0) + (QPtrW+1)'(push.v1);
    wp_nxt  = wp_r + n_push[QPtrW-1:0];
    rp_nxt  = rp_r + QPtrW'(pop);
    cnt_nxt = cnt_r + n_push - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wp_r] <= push.r0;
    if (push.v1) mem_r[wp_r + QPtrW'(1)] <= push.r1;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPtrW+1)'(QDepth))
    else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> (push.v0 && push.r1.last && !push.r0.last))
    else $error("second result without a first");

endmodule
